// ===== rtl/core/sapad_pkg.sv =====
package sapad_pkg;

  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 13;
  localparam int OFF_W   = 12;
  localparam int ALIGN_W = 9;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 1;

  localparam logic [CNT_W-1:0]   REGION_BYTES = 13'd4096;
  localparam logic [ALIGN_W-1:0] MAX_ALIGN    = 9'd256;
  localparam logic [ALIGN_W-1:0] HEADER_BYTES = 9'd4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREEALL = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_REGION = 3'd1;
  localparam logic [STAT_W-1:0] ST_BOUNDS    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ALIGN     = 3'd3;
  localparam logic [STAT_W-1:0] ST_POINTER   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_REGION_BASE  = 1'd0;
  localparam logic [CFG_W-1:0] CFG_REGION_BYTES = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CNT_W-1:0]   request_size;
    logic [ALIGN_W-1:0] align_bytes;
    logic [ADDR_W-1:0]  block_address;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  bytes_in_use;
  } out_item_t;

endpackage

// ===== rtl/core/stack_allocator_with_padding_header_core.sv =====
// stack allocator with a padding header over one region
// allocate: a 32-step remainder unit, then padding, then bounds check and write;
//   deallocate: one padding memory read; other and rejected commands finish straight from idle
// one command at a time: a new one is taken only while busy is low
// results are shown for one cycle with done high; the receiver cannot stall
// reset (rst, synchronous): used count, configuration registers, control cleared; padding memory undefined
module stack_allocator_with_padding_header_core
  import sapad_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         command,
  output logic             done,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;

  logic [2:0]          state;

  // configuration registers
  logic [ADDR_W-1:0]   region_base;
  logic [CNT_W-1:0]    region_bytes;

  // allocator state
  logic [CNT_W-1:0]    used;

  // per-command working registers
  logic [CNT_W-1:0]    size_r;
  logic [ALIGN_W-1:0]  align_r;
  logic [ADDR_W-1:0]   top_r;
  logic [ADDR_W-1:0]   dividend;
  logic [ALIGN_W-1:0]  rem;
  logic [4:0]          cnt;
  logic [ALIGN_W-1:0]  pad_r;
  logic [OFF_W-1:0]    off_r;

  // padding memory, one entry per region offset
  logic [ALIGN_W-1:0]  pad_mem [0:(1<<OFF_W)-1];
  logic [ALIGN_W-1:0]  pad_rd;
  logic                mem_we;
  logic [OFF_W-1:0]    mem_waddr;
  logic [OFF_W-1:0]    mem_raddr;

  // combinational helpers
  logic [CNT_W-1:0]    lim;
  logic [ADDR_W-1:0]   off_full;
  logic                ptr_ok;
  logic                align_bad;
  logic                accept;
  logic [ALIGN_W:0]    rem_sh;
  logic [ALIGN_W-1:0]  rem_next;
  logic [ALIGN_W-1:0]  gap;
  logic [ALIGN_W-1:0]  pad_next;
  logic [CNT_W:0]      blk;
  logic [CNT_W:0]      blk_end;
  logic                fits;
  logic [ADDR_W-1:0]   granted;
  logic [CNT_W-1:0]    dealloc_used;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // usable size is capped at the memory depth
  assign lim = (region_bytes > REGION_BYTES) ? REGION_BYTES : region_bytes;

  // pointer offset wraps modulo 2^32
  assign off_full  = command.block_address - region_base;
  assign ptr_ok    = off_full < {{(ADDR_W-CNT_W){1'b0}}, lim};
  assign align_bad = (command.align_bytes == '0) || (command.align_bytes > MAX_ALIGN);

  // one restoring step of top % align, one dividend bit a cycle
  always_comb begin
    rem_sh = {rem, dividend[ADDR_W-1]};
    if (rem_sh >= {1'b0, align_r}) begin
      rem_next = ALIGN_W'(rem_sh - {1'b0, align_r});
    end else begin
      rem_next = rem_sh[ALIGN_W-1:0];
    end
  end

  // gap to the next multiple strictly above, widened until the header fits
  always_comb begin
    gap = align_r - rem;
    if (gap < HEADER_BYTES) begin
      case (align_r)
        9'd1:    pad_next = HEADER_BYTES;
        9'd2:    pad_next = (gap == 9'd1) ? 9'd5 : HEADER_BYTES;
        9'd3:    pad_next = gap + 9'd3;
        default: pad_next = gap + align_r;
      endcase
    end else begin
      pad_next = gap;
    end
  end

  // bounds check on the block offset and its end
  assign blk     = {1'b0, used} + {{(CNT_W+1-ALIGN_W){1'b0}}, pad_r};
  assign blk_end = blk + {1'b0, size_r};
  assign fits    = (blk < {1'b0, lim}) && (blk_end <= {1'b0, lim});
  assign granted = top_r + {{(ADDR_W-ALIGN_W){1'b0}}, pad_r};

  // roll back to before the released block, clamped at zero
  assign dealloc_used = ({{(OFF_W-ALIGN_W){1'b0}}, pad_rd} > off_r) ? '0
                      : {1'b0, off_r - {{(OFF_W-ALIGN_W){1'b0}}, pad_rd}};

  assign mem_we    = (state == S_CHK) && fits;
  assign mem_waddr = blk[OFF_W-1:0];
  assign mem_raddr = off_full[OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pad_mem[mem_waddr] <= pad_r;
    end
    pad_rd <= pad_mem[mem_raddr];
  end

  // configuration write channel
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REGION_BASE:  region_base  <= cfg_data;
        CFG_REGION_BYTES: region_bytes <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      result.granted_address <= '0;
      case (command.cmd)
        CMD_ALLOC: begin
          result.status       <= (region_base == '0) ? ST_NO_REGION : ST_ALIGN;
          result.bytes_in_use <= used;
        end
        CMD_DEALLOC: begin
          result.status       <= (region_base == '0) ? ST_NO_REGION : ST_POINTER;
          result.bytes_in_use <= used;
        end
        CMD_FREEALL: begin
          result.status       <= ST_OK;
          result.bytes_in_use <= '0;
        end
        default: begin
          result.status       <= ST_OK;
          result.bytes_in_use <= used;
        end
      endcase
    end else if (state == S_CHK) begin
      result.status          <= fits ? ST_OK : ST_BOUNDS;
      result.granted_address <= fits ? granted : '0;
      result.bytes_in_use    <= fits ? blk_end[CNT_W-1:0] : used;
    end else if (state == S_RD) begin
      result.status          <= ST_OK;
      result.granted_address <= '0;
      result.bytes_in_use    <= dealloc_used;
    end
  end

  // working registers for the current transaction
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        size_r   <= command.request_size;
        align_r  <= command.align_bytes;
        top_r    <= region_base + {{(ADDR_W-CNT_W){1'b0}}, used};
        dividend <= region_base + {{(ADDR_W-CNT_W){1'b0}}, used};
        rem      <= '0;
        cnt      <= 5'd31;
        off_r    <= off_full[OFF_W-1:0];
      end
      S_DIV: begin
        dividend <= {dividend[ADDR_W-2:0], 1'b0};
        rem      <= rem_next;
        cnt      <= cnt - 5'd1;
      end
      S_PAD: begin
        pad_r <= pad_next;
      end
      default: ;
    endcase
  end

  // sequencer, used count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (command.cmd)
              CMD_ALLOC: begin
                if (region_base == '0 || align_bad) begin
                  done <= 1'b1;
                end else begin
                  state <= S_DIV;
                end
              end
              CMD_DEALLOC: begin
                if (region_base == '0 || !ptr_ok) begin
                  done <= 1'b1;
                end else begin
                  state <= S_RD;
                end
              end
              CMD_FREEALL: begin
                used <= '0;
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (fits) begin
            used <= blk_end[CNT_W-1:0];
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_RD: begin
          used  <= dealloc_used;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an error result never carries a block address
  a_err_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.granted_address == '0))
    else $error("error result with nonzero address");

  // the used count never passes the memory depth
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= REGION_BYTES)
    else $error("used count beyond region");

  // the padding memory is only written inside the usable region
  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (blk < {1'b0, lim}))
    else $error("padding write outside region");

  // a result strobe always lands with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while busy");
`endif

endmodule

// ===== dv/stack_alloc_checker.sv =====
module stack_alloc_checker
  import sapad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          command,
  input  logic              done,
  input  out_item_t         result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  output int                failures,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam int STORE_DEPTH = 4096;

  logic [ADDR_W-1:0]  base_reg;
  logic [CNT_W-1:0]   span_reg;
  logic [CNT_W-1:0]   top_offset;
  logic [ALIGN_W-1:0] pad_table [STORE_DEPTH];
  out_item_t          awaited_results [$];
  int                 mismatches = 0;

  always @(posedge clk) begin : scoreboard
    out_item_t   want;
    out_item_t   pred;
    int unsigned limit;
    int unsigned top;
    int unsigned gap;
    int unsigned missing;
    int unsigned blk;
    int unsigned off;
    if (rst) begin
      base_reg   = '0;
      span_reg   = '0;
      top_offset = '0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REGION_BASE) begin
          base_reg = cfg_data;
        end else if (cfg_index == CFG_REGION_BYTES) begin
          span_reg = cfg_data[CNT_W-1:0];
        end
      end

      if (done) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result with nothing outstanding: status=%0d addr=%h used=%0d",
                     $time, result.status, result.granted_address, result.bytes_in_use);
          end
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status ||
              result.granted_address !== want.granted_address ||
              result.bytes_in_use !== want.bytes_in_use) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected status=%0d addr=%h used=%0d, got status=%0d addr=%h used=%0d",
                       $time, want.status, want.granted_address, want.bytes_in_use,
                       result.status, result.granted_address, result.bytes_in_use);
            end
          end
        end
      end

      if (start && !busy) begin
        limit = (span_reg > REGION_BYTES) ? REGION_BYTES : span_reg;
        pred = '0;
        pred.status = ST_OK;
        case (command.cmd)
          CMD_ALLOC: begin
            if (base_reg == '0) begin
              pred.status = ST_NO_REGION;
            end else if (command.align_bytes == '0 || command.align_bytes > MAX_ALIGN) begin
              pred.status = ST_ALIGN;
            end else begin
              // next multiple strictly above the top, widened until the header fits
              top = base_reg + top_offset;
              gap = command.align_bytes - (top % command.align_bytes);
              if (gap < HEADER_BYTES) begin
                missing = HEADER_BYTES - gap;
                gap += command.align_bytes *
                       ((missing + command.align_bytes - 1) / command.align_bytes);
              end
              blk = top_offset + gap;
              if (blk >= limit || blk + command.request_size > limit) begin
                pred.status = ST_BOUNDS;
              end else begin
                pad_table[blk[OFF_W-1:0]] = gap[ALIGN_W-1:0];
                top_offset = CNT_W'(blk + command.request_size);
                pred.granted_address = top + gap;
              end
            end
          end
          CMD_DEALLOC: begin
            if (base_reg == '0) begin
              pred.status = ST_NO_REGION;
            end else begin
              off = command.block_address - base_reg;
              if (off >= limit) begin
                pred.status = ST_POINTER;
              end else begin
                gap = pad_table[off[OFF_W-1:0]];
                top_offset = (gap > off) ? '0 : CNT_W'(off - gap);
              end
            end
          end
          CMD_FREEALL: begin
            top_offset = '0;
          end
          default: ;
        endcase
        pred.bytes_in_use = top_offset;
        awaited_results.push_back(pred);
      end
    end
    pending  = awaited_results.size();
    failures = mismatches;
  end

endmodule

// ===== dv/tb_stack_allocator_with_padding_header_core.sv =====
module tb_stack_allocator_with_padding_header_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sapad_pkg::*;

  // the one command code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1330;
  localparam int PHASE_ITEMS    = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  in_item_t          command;
  logic              done;
  out_item_t         result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_index;
  logic [ADDR_W-1:0] cfg_data;

  int failures;
  int pending;
  int idle_cycles = 0;

  // shadow of the current region, only changed while the block is idle
  logic [ADDR_W-1:0] cur_base  = '0;
  int unsigned       cur_limit = 0;

  // offsets whose padding entry has been written; deallocates only read these
  bit                written_pad [4096];
  // offsets of live blocks, oldest first, learned from granted addresses
  int unsigned       live_blocks [$];
  // commands accepted but still waiting for their result
  in_item_t          issued [$];

  stack_allocator_with_padding_header_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stack_alloc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall detector: any cycle with no transaction on any channel counts
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // follow the stack from the results so that deallocates name real blocks
  always @(posedge clk) begin : track_blocks
    in_item_t          finished;
    logic [ADDR_W-1:0] off;
    int                idx;
    int                k;
    if (rst) begin
      issued.delete();
      live_blocks.delete();
    end else begin
      if (start && !busy) begin
        issued.push_back(command);
      end
      if (done && issued.size() != 0) begin
        finished = issued.pop_front();
        if (result.status == ST_OK) begin
          if (finished.cmd == CMD_ALLOC) begin
            off = result.granted_address - cur_base;
            if (off < REGION_BYTES) begin
              written_pad[off[OFF_W-1:0]] = 1'b1;
              live_blocks.push_back(off);
            end
          end else if (finished.cmd == CMD_DEALLOC) begin
            // releasing a live block drops it and everything above it
            off = finished.block_address - cur_base;
            idx = -1;
            for (k = 0; k < live_blocks.size(); k++) begin
              if (idx < 0 && live_blocks[k] == off) idx = k;
            end
            if (idx < 0) begin
              live_blocks.delete();
            end else begin
              while (live_blocks.size() > idx) void'(live_blocks.pop_back());
            end
          end else if (finished.cmd == CMD_FREEALL) begin
            live_blocks.delete();
          end
        end
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(input logic [CMD_W-1:0]   c,
                                         input logic [CNT_W-1:0]   size,
                                         input logic [ALIGN_W-1:0] align,
                                         input logic [ADDR_W-1:0]  addr);
    in_item_t it;
    it.cmd           = c;
    it.request_size  = size;
    it.align_bytes   = align;
    it.block_address = addr;
    return it;
  endfunction

  // a deallocate pointer that is outside the region or names a written entry
  function automatic logic [ADDR_W-1:0] stray_address();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] off;
    case ($urandom_range(0, 3))
      0: a = $urandom;
      1: a = cur_base + $urandom_range(0, 4095);
      2: a = cur_base - $urandom_range(1, 16);
      default: a = cur_base + cur_limit + $urandom_range(0, 16);
    endcase
    off = a - cur_base;
    if (cur_base != '0 && off < cur_limit && !written_pad[off[OFF_W-1:0]]) begin
      a = cur_base + cur_limit + $urandom_range(0, 32'hFFFF_0000);
    end
    return a;
  endfunction

  // start stays high when the next transaction follows at once
  task automatic send_command(input in_item_t item);
    start   <= 1'b1;
    command <= item;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (issued.size() != 0 || pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] index, input logic [ADDR_W-1:0] data);
    int g;
    g = idle_len();
    if (g > 0) begin
      cfg_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_region(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] span);
    logic [ADDR_W-CNT_W-1:0] junk;
    junk = $urandom;
    wait_idle();
    write_reg(CFG_REGION_BASE, base);
    // upper data bits are not part of the size register
    write_reg(CFG_REGION_BYTES, {junk, span});
    cfg_valid <= 1'b0;
    cur_base  = base;
    cur_limit = (span > REGION_BYTES) ? REGION_BYTES : span;
  endtask

  // release the newest live block, or a harmless stray pointer if none
  task automatic release_top();
    logic [ADDR_W-1:0] addr;
    wait_idle();
    if (live_blocks.size() != 0) addr = cur_base + live_blocks[$];
    else addr = stray_address();
    send_command(make_item(CMD_DEALLOC, $urandom, $urandom, addr));
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   size_v;
    logic [ALIGN_W-1:0] align_v;
    int                 p;
    int                 q;

    rst       <= 1'b1;
    start     <= 1'b0;
    command   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing configured: allocate and deallocate report no region
    send_command(make_item(CMD_ALLOC, 13'd8, 9'd4, $urandom));
    send_command(make_item(CMD_DEALLOC, $urandom, $urandom, $urandom));
    send_command(make_item(CMD_FREEALL, $urandom, $urandom, $urandom));
    send_command(make_item(CMD_UNUSED, $urandom, $urandom, $urandom));

    set_region(32'h0000_1000, 13'd4096);
    send_command(make_item(CMD_ALLOC, 13'd0, 9'd1, $urandom));
    send_command(make_item(CMD_ALLOC, 13'd3, 9'd2, $urandom));
    send_command(make_item(CMD_ALLOC, 13'd16, 9'd256, $urandom));
    // free all, then release the last block: count jumps above the top
    wait_idle();
    if (live_blocks.size() != 0) addr = cur_base + live_blocks[$];
    else addr = stray_address();
    send_command(make_item(CMD_FREEALL, 13'd0, 9'd0, 32'd0));
    send_command(make_item(CMD_DEALLOC, 13'h1FFF, 9'h1FF, addr));
    send_command(make_item(CMD_ALLOC, 13'd7, 9'd8, $urandom));
    release_top();
    // alignment above the maximum, zero alignment, oversize request
    send_command(make_item(CMD_ALLOC, 13'h1FFF, 9'h1FF, $urandom));
    send_command(make_item(CMD_ALLOC, 13'd5, 9'd0, $urandom));
    send_command(make_item(CMD_ALLOC, 13'h1FFF, 9'd256, $urandom));
    // pointers just outside the region on both sides
    send_command(make_item(CMD_DEALLOC, $urandom, $urandom, cur_base - 32'd1));
    send_command(make_item(CMD_DEALLOC, $urandom, $urandom, cur_base + 32'd4096));

    // block offset landing exactly on the limit with a zero-size request
    set_region(32'h0000_1000, 13'd64);
    send_command(make_item(CMD_FREEALL, $urandom, $urandom, $urandom));
    send_command(make_item(CMD_ALLOC, 13'd56, 9'd4, $urandom));
    send_command(make_item(CMD_ALLOC, 13'd0, 9'd4, $urandom));

    // top address wraps past 2^32, size register above the usable limit
    set_region(32'hFFFF_FFF0, 13'h1FFF);
    send_command(make_item(CMD_ALLOC, 13'd8, 9'd16, $urandom));
    send_command(make_item(CMD_ALLOC, 13'h1FFF, 9'd1, $urandom));

    // empty region
    set_region($urandom | 32'd1, 13'd0);
    send_command(make_item(CMD_ALLOC, 13'd0, 9'd1, $urandom));
    send_command(make_item(CMD_DEALLOC, $urandom, $urandom, cur_base));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 7))
          0: set_region(32'd0, $urandom_range(0, 8191));
          1: set_region(32'hFFFF_FFFF, 13'd4096);
          2: set_region(32'hFFFF_F000 + $urandom_range(0, 4095), $urandom_range(64, 4096));
          3: set_region(($urandom % 32'hFFFF_FFFF) + 32'd1, $urandom_range(0, 8191));
          4: set_region(($urandom & 32'hFFFF_F000) | 32'h0000_1000, 13'd4096);
          default: set_region(($urandom % 32'hFFFF_FFFF) + 32'd1, $urandom_range(16, 512));
        endcase
      end

      p = $urandom_range(0, 99);
      if (p < 55) begin
        q = $urandom_range(0, 99);
        size_v = (q < 70) ? $urandom_range(0, 32) :
                 (q < 90) ? $urandom_range(33, 512) :
                 (q < 97) ? $urandom_range(513, 4096) : $urandom_range(0, 8191);
        q = $urandom_range(0, 99);
        align_v = (q < 75) ? (9'd1 << $urandom_range(0, 8)) :
                  (q < 90) ? $urandom_range(1, 256) :
                  (q < 95) ? 9'd0 : $urandom_range(257, 511);
        send_command(make_item(CMD_ALLOC, size_v, align_v, $urandom));
      end else if (p < 80) begin
        release_top();
      end else if (p < 85) begin
        // release a block below the newest one
        wait_idle();
        if (live_blocks.size() > 1) begin
          addr = cur_base + live_blocks[$urandom_range(0, live_blocks.size() - 2)];
        end else begin
          addr = stray_address();
        end
        send_command(make_item(CMD_DEALLOC, $urandom, $urandom, addr));
      end else if (p < 91) begin
        send_command(make_item(CMD_DEALLOC, $urandom, $urandom, stray_address()));
      end else if (p < 96) begin
        send_command(make_item(CMD_FREEALL, $urandom, $urandom, $urandom));
      end else begin
        send_command(make_item(CMD_UNUSED, $urandom, $urandom, $urandom));
      end

      // a burst without gaps at the start of every 200 items
      if (i % 200 >= 30) pause(idle_len());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
